@@ rtl/twcw_pkg.sv @@
// ----------------------------------------------------------------------------
// twcw_pkg
// Shared types and constants of the text window character writer: control
// codes, register indexes, reset values and the configuration and result
// records passed between modules.
// ----------------------------------------------------------------------------
package twcw_pkg;

    // Control codes handled by the writer
    localparam logic [7:0] CHAR_BEL = 8'h07;
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_CR  = 8'h0d;

    // Configuration bus geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_WIN_TOP    = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIN_RIGHT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEXT_ATTR  = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_WIN_LEFT   = 8'd0;
    localparam logic [7:0] RST_WIN_TOP    = 8'd0;
    localparam logic [7:0] RST_WIN_RIGHT  = 8'd79;
    localparam logic [7:0] RST_WIN_BOTTOM = 8'd24;
    localparam logic [7:0] RST_TEXT_ATTR  = 8'd7;

    // Window and attribute settings
    typedef struct packed {
        logic [7:0] win_left;
        logic [7:0] win_top;
        logic [7:0] win_right;
        logic [7:0] win_bottom;
        logic [7:0] text_attr;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_col;
        logic [7:0] write_row;
        logic [7:0] write_char;
        logic [7:0] write_attr;
        logic       scroll_up;
        logic       bell;
        logic [7:0] new_col;
        logic [7:0] new_row;
    } t_result;

endpackage

@@ rtl/twcw_cfg.sv @@
// ----------------------------------------------------------------------------
// twcw_cfg
// Configuration register file behind an APB-style port: window edges and
// text attribute, with read back.
// ----------------------------------------------------------------------------
module twcw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twcw_pkg::ADDR_W-1:0]   paddr,
    input  logic [twcw_pkg::DATA_W-1:0]   pwdata,
    output logic [twcw_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output twcw_pkg::t_cfg                o_cfg
);

    twcw_pkg::t_cfg              r_cfg;
    twcw_pkg::t_cfg              n_cfg;
    logic [twcw_pkg::IDX_W-1:0]  reg_idx;
    logic                        wr_en;
    logic [7:0]                  rd_byte;

    assign pready  = 1'b1;
    assign reg_idx = paddr[twcw_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                twcw_pkg::REG_WIN_LEFT:   n_cfg.win_left   = pwdata[7:0];
                twcw_pkg::REG_WIN_TOP:    n_cfg.win_top    = pwdata[7:0];
                twcw_pkg::REG_WIN_RIGHT:  n_cfg.win_right  = pwdata[7:0];
                twcw_pkg::REG_WIN_BOTTOM: n_cfg.win_bottom = pwdata[7:0];
                twcw_pkg::REG_TEXT_ATTR:  n_cfg.text_attr  = pwdata[7:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_left   <= twcw_pkg::RST_WIN_LEFT;
            r_cfg.win_top    <= twcw_pkg::RST_WIN_TOP;
            r_cfg.win_right  <= twcw_pkg::RST_WIN_RIGHT;
            r_cfg.win_bottom <= twcw_pkg::RST_WIN_BOTTOM;
            r_cfg.text_attr  <= twcw_pkg::RST_TEXT_ATTR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            twcw_pkg::REG_WIN_LEFT:   rd_byte = r_cfg.win_left;
            twcw_pkg::REG_WIN_TOP:    rd_byte = r_cfg.win_top;
            twcw_pkg::REG_WIN_RIGHT:  rd_byte = r_cfg.win_right;
            twcw_pkg::REG_WIN_BOTTOM: rd_byte = r_cfg.win_bottom;
            twcw_pkg::REG_TEXT_ATTR:  rd_byte = r_cfg.text_attr;
            default:                  rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(twcw_pkg::DATA_W-8){1'b0}}, rd_byte};
    assign o_cfg  = r_cfg;

endmodule

@@ rtl/twcw_step.sv @@
// ----------------------------------------------------------------------------
// twcw_step
// Cursor registers and the per-character decision: bell, backspace,
// carriage return, line feed with scroll request, or cell write and advance.
// ----------------------------------------------------------------------------
module twcw_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twcw_pkg::t_cfg    i_cfg,
    input  logic              i_advance,
    input  logic [7:0]        i_char,
    output twcw_pkg::t_result o_result
);

    logic [7:0] r_col;
    logic [7:0] r_row;
    logic [7:0] n_col;
    logic [7:0] n_row;
    logic [7:0] col_inc;
    logic [8:0] row_inc;
    logic       row_fits;
    logic       col_wrap;

    assign col_inc  = r_col + 8'd1;
    assign col_wrap = col_inc > i_cfg.win_right;
    // Next-row compare is 9 bits wide, so the last row never moves down
    assign row_inc  = {1'b0, r_row} + 9'd1;
    assign row_fits = row_inc <= {1'b0, i_cfg.win_bottom};

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        o_result = '0;
        case (i_char)
            twcw_pkg::CHAR_BEL: begin
                o_result.bell = 1'b1;
            end
            twcw_pkg::CHAR_BS: begin
                if (r_col != i_cfg.win_left) begin
                    n_col = r_col - 8'd1;
                end
            end
            twcw_pkg::CHAR_LF: begin
                if (row_fits) begin
                    n_row = row_inc[7:0];
                end
                o_result.scroll_up = !row_fits;
            end
            twcw_pkg::CHAR_CR: begin
                n_col = i_cfg.win_left;
            end
            default: begin
                o_result.write_valid = 1'b1;
                o_result.write_col   = r_col;
                o_result.write_row   = r_row;
                o_result.write_char  = i_char;
                o_result.write_attr  = i_cfg.text_attr;
                n_col                = col_inc;
                // Past the right edge: back to the left edge on a new line
                if (col_wrap) begin
                    n_col = i_cfg.win_left;
                    if (row_fits) begin
                        n_row = row_inc[7:0];
                    end
                    o_result.scroll_up = !row_fits;
                end
            end
        endcase
        o_result.new_col = n_col;
        o_result.new_row = n_row;
    end

    // Commit the cursor when the character moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ rtl/text_window_char_writer.sv @@
// One character is accepted per clock and its result passes through the
// input register, then the result register; the cursor update is a
// combinational loop through the compare and select logic, so back-to-back
// characters run at one per cycle for as long as the result side does not
// stall. Every character gives exactly one result beat carrying the new
// cursor, plus a cell write, a scroll-up request or a bell flag as the code
// demands. Window edges and attribute sit at byte addresses 0, 4, 8, 12, 16
// (left, top, right, bottom, attribute) and should be written while idle.
// ----------------------------------------------------------------------------
// text_window_char_writer
// Top level: input register, cursor step logic, result register and the
// configuration port.
// ----------------------------------------------------------------------------
module text_window_char_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twcw_pkg::ADDR_W-1:0]   paddr,
    input  logic [twcw_pkg::DATA_W-1:0]   pwdata,
    output logic [twcw_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_char_code,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_write_valid,
    output logic [7:0]                    o_write_col,
    output logic [7:0]                    o_write_row,
    output logic [7:0]                    o_write_char,
    output logic [7:0]                    o_write_attr,
    output logic                          o_scroll_up,
    output logic                          o_bell,
    output logic [7:0]                    o_new_col,
    output logic [7:0]                    o_new_row
);

    twcw_pkg::t_cfg    cfg;
    twcw_pkg::t_result step_res;
    twcw_pkg::t_result r_out_res;
    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_out_valid;
    logic              n_in_valid;
    logic              n_out_valid;
    logic              out_ready;
    logic              in_ready;
    logic              advance;

    twcw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    twcw_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_char    (r_in_char),
        .o_result  (step_res)
    );

    // Handshake: each stage moves when the one after it has room
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_in_valid || out_ready;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = !in_ready;

    assign n_in_valid  = in_ready ? i_in_valid : r_in_valid;
    assign n_out_valid = out_ready ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the character and the result beat
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_char <= i_char_code;
        end
        if (advance) begin
            r_out_res <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_valid = r_out_res.write_valid;
    assign o_write_col   = r_out_res.write_col;
    assign o_write_row   = r_out_res.write_row;
    assign o_write_char  = r_out_res.write_char;
    assign o_write_attr  = r_out_res.write_attr;
    assign o_scroll_up   = r_out_res.scroll_up;
    assign o_bell        = r_out_res.bell;
    assign o_new_col     = r_out_res.new_col;
    assign o_new_row     = r_out_res.new_row;

endmodule

@@ rtl/twcw_checker.sv @@
// ----------------------------------------------------------------------------
// twcw_checker
// Port-level checks of the text window character writer, bound to the top.
// ----------------------------------------------------------------------------
module twcw_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_in_stall,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic       o_write_valid,
    input  logic [7:0] o_write_col,
    input  logic [7:0] o_write_row,
    input  logic [7:0] o_write_char,
    input  logic [7:0] o_write_attr,
    input  logic       o_scroll_up,
    input  logic       o_bell,
    input  logic [7:0] o_new_col,
    input  logic [7:0] o_new_row
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_new_col) && $stable(o_new_row)
            && $stable(o_write_valid) && $stable(o_scroll_up) && $stable(o_bell))
        else $error("stalled result beat changed");

    // Never stall input while the result register is empty
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // Zero the write fields on beats without a cell write
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |->
            o_write_col == 8'd0 && o_write_row == 8'd0
            && o_write_char == 8'd0 && o_write_attr == 8'd0)
        else $error("write fields set without a cell write");

    // A bell does nothing else
    a_bell_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bell |-> !o_write_valid && !o_scroll_up)
        else $error("bell beat also writes or scrolls");

endmodule

bind text_window_char_writer twcw_checker u_twcw_checker (.*);
